>>> rtl/core/qwalu_pkg.sv
`timescale 1ns / 1ps
package qwalu_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_SHL = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_NEGATIVE = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_DIVZERO  = 3'd4;

  localparam int SHIFT_LIMIT = 32;
  localparam int MUL_BITS    = 32;
  localparam int DIV_BITS    = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [15:0] remainder;
    logic [2:0]  status;
  } out_item_t;

  // classified work entry between front and back
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
    logic        b_big;    // shift count above limit
    logic        d_zero;   // divisor zero
  } work_t;

endpackage

>>> rtl/core/quadword_integer_alu.sv
`timescale 1ns / 1ps
// Unsigned 64-bit ALU: add, subtract, multiply by the low 32 bits of B,
// divide by the low 16 bits of B with remainder, and shift left by 0..32.
// Both sides are queues: push/full in, empty/pop out. One item is accepted
// per cycle sustained while full stays low. An accepted item waits in the
// work queue, then passes 16 execute stages (two multiplier bits and four
// quotient bits per stage), the last of which writes the output queue,
// from which its result can be popped.
// full rises only when results are not popped: the back end stops taking
// work once the output queue has no credit left, and the work queue fills.
// Status reports overflow, negative difference, oversized shift or zero
// divisor. No kept state.
module quadword_integer_alu #(
  parameter int Depth = qwalu_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  qwalu_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output qwalu_pkg::out_item_t out_item
);
  logic             wq_valid, wq_take;
  qwalu_pkg::work_t wq_item;

  // front: classify and queue
  qwalu_front #(.Depth(Depth)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .wq_valid, .wq_take, .wq_item
  );

  // back: pipelined execute with credit-based output queue
  qwalu_back #(.Depth(Depth)) u_back (
    .clk, .rst_n, .wq_valid, .wq_take, .wq_item,
    .out_empty, .out_pop, .out_item
  );

  // taking work only when the front has some
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    wq_take |-> wq_valid) else $error("take without work");
  // an accepted item leaves the front non-empty next cycle
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> wq_valid) else $error("item lost in front");
  // a zero divisor never yields a nonzero remainder
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.status == qwalu_pkg::ST_DIVZERO)
      |-> out_item.remainder == 16'd0) else $error("bad remainder");
endmodule

>>> rtl/core/qwalu_front.sv
`timescale 1ns / 1ps
// Classifies input items and holds them in a small queue for the back end.
module qwalu_front #(
  parameter int Depth = qwalu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  qwalu_pkg::in_item_t in_item,
  output logic               wq_valid,
  input  logic               wq_take,
  output qwalu_pkg::work_t   wq_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  qwalu_pkg::work_t mem [Depth];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  qwalu_pkg::work_t w;
  logic push_ok, take_ok;

  always_comb begin
    w.kind   = in_item.kind;
    w.a      = in_item.operand_a;
    w.b      = in_item.operand_b;
    w.b_big  = in_item.operand_b > 64'(qwalu_pkg::SHIFT_LIMIT);
    w.d_zero = in_item.operand_b[15:0] == 16'd0;
  end

  assign in_full  = cnt_r == (AW+1)'(Depth);
  assign wq_valid = cnt_r != '0;
  assign wq_item  = mem[rd_r];
  assign push_ok  = in_push && !in_full;
  assign take_ok  = wq_take && wq_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_r] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wr_r <= (wr_r == AW'(Depth-1)) ? '0 : wr_r + 1'b1;
      if (take_ok) rd_r <= (rd_r == AW'(Depth-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push_ok) - (AW+1)'(take_ok);
    end
  end
endmodule

>>> rtl/core/qwalu_back.sv
`timescale 1ns / 1ps
// Pipelined execute: stage s (1..16) handles multiply bits 2s-2, 2s-1 and
// four divide quotient bits; then an output queue.
module qwalu_back #(
  parameter int Depth = qwalu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wq_valid,
  output logic                wq_take,
  input  qwalu_pkg::work_t    wq_item,
  output logic                out_empty,
  input  logic                out_pop,
  output qwalu_pkg::out_item_t out_item
);
  localparam int NS = qwalu_pkg::MUL_BITS / 2;  // 16 stages
  localparam int OD = Depth + NS + 1;
  localparam int OW = $clog2(OD + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
    logic        b_big;
    logic        d_zero;
    logic [63:0] acc;   // multiply accumulator / divide quotient
    logic [16:0] rem;
    logic        ovf;
  } stg_t;

  stg_t st_in;
  logic vl_in;
  stg_t st_r [1:NS];
  logic vl_r [1:NS];
  logic [OW-1:0] inflight_r;
  logic [OW-1:0] ocnt_r;
  logic take_ok, pop_ok;

  // credit: never start more than the output queue can hold
  assign wq_take = wq_valid && (inflight_r + ocnt_r < OW'(OD));
  assign take_ok = wq_take;

  always_comb begin
    st_in.kind   = wq_item.kind;
    st_in.a      = wq_item.a;
    st_in.b      = wq_item.b;
    st_in.b_big  = wq_item.b_big;
    st_in.d_zero = wq_item.d_zero;
    st_in.acc    = '0;
    st_in.rem    = '0;
    st_in.ovf    = 1'b0;
    vl_in        = take_ok;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    stg_t cur;
    logic cur_vl;
    stg_t n;
    if (s == 0) begin : g_head
      assign cur    = st_in;
      assign cur_vl = vl_in;
    end else begin : g_body
      assign cur    = st_r[s];
      assign cur_vl = vl_r[s];
    end
    always_comb begin
      logic [64:0] sum;
      logic [16:0] r;
      logic [15:0] d;
      sum = '0;
      r = '0;
      n = cur;
      d = cur.b[15:0];
      if (cur.kind == qwalu_pkg::KIND_MUL) begin
        for (int k = 0; k < 2; k++) begin
          if (cur.b[2*s+k]) begin
            sum = {1'b0, n.acc} + {1'b0, cur.a << (2*s+k)};
            if (sum[64]) begin
              n.acc = '0;
              n.ovf = 1'b1;
            end else begin
              n.acc = sum[63:0];
            end
          end
        end
      end else if (cur.kind == qwalu_pkg::KIND_DIV && !cur.d_zero) begin
        r = n.rem;
        for (int k = 0; k < 4; k++) begin
          r = {r[15:0], cur.a[63 - 4*s - k]};
          n.acc = {n.acc[62:0], 1'b0};
          if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            n.acc[0] = 1'b1;
          end
        end
        n.rem = r;
      end
    end
    always_ff @(posedge clk) begin
      st_r[s+1] <= n;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vl_r[s+1] <= 1'b0;
      else vl_r[s+1] <= cur_vl;
    end
  end

  // final result
  qwalu_pkg::out_item_t res;
  stg_t f;
  logic [64:0] asum;
  always_comb begin
    f = st_r[NS];
    asum = {1'b0, f.a} + {1'b0, f.b};
    res = '0;
    unique case (f.kind)
      qwalu_pkg::KIND_ADD: begin
        if (asum[64]) res.status = qwalu_pkg::ST_OVERFLOW;
        else res.result_value = asum[63:0];
      end
      qwalu_pkg::KIND_SUB: begin
        if (f.a < f.b) begin
          res.result_value = f.a;
          res.status = qwalu_pkg::ST_NEGATIVE;
        end else begin
          res.result_value = f.a - f.b;
        end
      end
      qwalu_pkg::KIND_MUL: begin
        res.result_value = f.acc;
        if (f.ovf) res.status = qwalu_pkg::ST_OVERFLOW;
      end
      qwalu_pkg::KIND_DIV: begin
        if (f.d_zero) begin
          res.status = qwalu_pkg::ST_DIVZERO;
        end else begin
          res.result_value = f.acc;
          res.remainder = f.rem[15:0];
        end
      end
      qwalu_pkg::KIND_SHL: begin
        if (f.b_big) res.status = qwalu_pkg::ST_SHIFT;
        else res.result_value = f.a << f.b[5:0];
      end
      default: res = '0;
    endcase
  end

  // output queue
  localparam int QW = $clog2(OD);
  qwalu_pkg::out_item_t oq [OD];
  logic [QW-1:0] ow_r, or_r;
  logic push_o;
  assign push_o = vl_r[NS];
  assign out_empty = ocnt_r == '0;
  assign out_item = oq[or_r];
  assign pop_ok = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (push_o) oq[ow_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_r <= '0;
      or_r <= '0;
      ocnt_r <= '0;
      inflight_r <= '0;
    end else begin
      if (push_o) ow_r <= (ow_r == QW'(OD-1)) ? '0 : ow_r + 1'b1;
      if (pop_ok) or_r <= (or_r == QW'(OD-1)) ? '0 : or_r + 1'b1;
      ocnt_r <= ocnt_r + OW'(push_o) - OW'(pop_ok);
      inflight_r <= inflight_r + OW'(take_ok) - OW'(push_o);
    end
  end
endmodule

>>> verif/quadword_integer_alu_test.sv
`timescale 1ns / 1ps
module quadword_integer_alu_test;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  qwalu_pkg::in_item_t  in_item;
  logic                 out_empty;
  logic                 out_pop;
  qwalu_pkg::out_item_t out_item;

  quadword_integer_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // items waiting to be offered, and results the ALU still owes us
  qwalu_pkg::in_item_t  op_queue[$];
  qwalu_pkg::out_item_t result_queue[$];

  int  send_idle_pct;   // chance per cycle that the sender sits out
  int  recv_stall_pct;  // chance per cycle that the receiver sits out
  int  hold_off_cycles; // long receiver hold-off, counted down below
  bit  hold_sender;     // sender paused until all results are in
  int  errors;
  int  cycle_count;

  // acceptance flag captured at the rising edge
  bit item_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Golden ALU behavior, computed directly from the operation definition.
  function automatic qwalu_pkg::out_item_t alu_result(qwalu_pkg::in_item_t it);
    qwalu_pkg::out_item_t r;
    logic [64:0] wide;
    logic [63:0] acc;
    logic [63:0] part;
    logic [15:0] divisor;
    r = '0;
    case (it.kind)
      qwalu_pkg::KIND_ADD: begin
        wide = {1'b0, it.operand_a} + {1'b0, it.operand_b};
        if (wide[64]) r.status = qwalu_pkg::ST_OVERFLOW;
        else r.result_value = wide[63:0];
      end
      qwalu_pkg::KIND_SUB: begin
        if (it.operand_a < it.operand_b) begin
          r.result_value = it.operand_a;
          r.status = qwalu_pkg::ST_NEGATIVE;
        end else begin
          r.result_value = it.operand_a - it.operand_b;
        end
      end
      qwalu_pkg::KIND_MUL: begin
        // shift-and-add; a carry out of any partial add clears the sum
        acc = '0;
        for (int i = 0; i < qwalu_pkg::MUL_BITS; i++) begin
          if (it.operand_b[i]) begin
            part = it.operand_a << i;
            wide = {1'b0, acc} + {1'b0, part};
            if (wide[64]) begin
              acc = '0;
              r.status = qwalu_pkg::ST_OVERFLOW;
            end else begin
              acc = wide[63:0];
            end
          end
        end
        r.result_value = acc;
      end
      qwalu_pkg::KIND_DIV: begin
        divisor = it.operand_b[15:0];
        if (divisor == '0) begin
          r.status = qwalu_pkg::ST_DIVZERO;
        end else begin
          r.result_value = it.operand_a / {48'd0, divisor};
          r.remainder = 16'(it.operand_a % {48'd0, divisor});
        end
      end
      qwalu_pkg::KIND_SHL: begin
        if (it.operand_b > 64'(qwalu_pkg::SHIFT_LIMIT)) r.status = qwalu_pkg::ST_SHIFT;
        else r.result_value = it.operand_a << it.operand_b[5:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(0, 70));
      3: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_op(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
    qwalu_pkg::in_item_t it;
    it.kind = kind;
    it.operand_a = a;
    it.operand_b = b;
    op_queue.push_back(it);
  endtask

  task automatic add_random_ops(int count);
    logic [2:0]  kind;
    logic [63:0] b;
    for (int n = 0; n < count; n++) begin
      // mostly legal kinds, a few undefined ones
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      b = rand64();
      if (kind == qwalu_pkg::KIND_SHL && $urandom_range(0, 2) != 0)
        b = 64'($urandom_range(0, 34));
      if (kind == qwalu_pkg::KIND_DIV && $urandom_range(0, 9) == 0)
        b[15:0] = '0;
      add_op(kind, rand64(), b);
    end
  endtask

  // wait until the driver has offered every pending item and all results are back
  task automatic wait_drained();
    while (op_queue.size() != 0 || in_push || result_queue.size() != 0)
      @(posedge clk);
  endtask

  // Driver: changes inputs at the falling edge; item_taken says the last
  // rising edge accepted the item on the ports.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if ((!in_push || item_taken) && !hold_sender && op_queue.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= op_queue.pop_front();
        in_push <= 1'b1;
      end else if (!in_push || item_taken) begin
        in_push <= 1'b0;
      end
      out_pop <= (hold_off_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off countdown
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: records accepted items and checks accepted results.
  always @(posedge clk) begin
    qwalu_pkg::out_item_t want;
    cycle_count <= cycle_count + 1;
    item_taken <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if (in_push && !in_full) begin
        result_queue.push_back(alu_result(in_item));
      end
      if (out_pop && !out_empty) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_item);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (want.result_value !== out_item.result_value)
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, out_item.result_value);
          if (want.remainder !== out_item.remainder)
            $display("%0t: remainder expected %h actual %h", $time,
                     want.remainder, out_item.remainder);
          if (want.status !== out_item.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_item.status);
          if (want !== out_item) errors++;
        end
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    in_item = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    hold_sender = 1'b0;
    errors = 0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: extremes, every kind, every status
    add_op(qwalu_pkg::KIND_ADD, '0, '0);
    add_op(qwalu_pkg::KIND_ADD, '1, 64'd1);                    // carry-only overflow
    add_op(qwalu_pkg::KIND_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_op(qwalu_pkg::KIND_ADD, '1, '0);
    add_op(qwalu_pkg::KIND_SUB, 64'd5, 64'd9);                 // negative difference
    add_op(qwalu_pkg::KIND_SUB, '1, '1);
    add_op(qwalu_pkg::KIND_SUB, '1, '0);
    add_op(qwalu_pkg::KIND_MUL, '1, '1);                       // overflowing partial sums
    add_op(qwalu_pkg::KIND_MUL, 64'd3, 64'hFFFF_FFFF_0000_0007);
    add_op(qwalu_pkg::KIND_MUL, '1, '0);
    add_op(qwalu_pkg::KIND_MUL, 64'h0000_0001_0000_0000, 64'h8000_0000);
    add_op(qwalu_pkg::KIND_DIV, '1, 64'd1);
    add_op(qwalu_pkg::KIND_DIV, '1, 64'hFFFF);
    add_op(qwalu_pkg::KIND_DIV, 64'd1234, 64'hFFFF_FFFF_FFFF_0000); // zero divisor
    add_op(qwalu_pkg::KIND_DIV, 64'd7, 64'd9);
    add_op(qwalu_pkg::KIND_SHL, '1, 64'd0);
    add_op(qwalu_pkg::KIND_SHL, '1, 64'd32);
    add_op(qwalu_pkg::KIND_SHL, '1, 64'd33);                   // shift above limit
    add_op(qwalu_pkg::KIND_SHL, '1, 64'h1_0000_0000);          // high count bits
    add_op(qwalu_pkg::KIND_SHL, '1, '1);
    add_op(3'd5, '1, '1);                                      // undefined kinds
    add_op(3'd7, '1, '1);
    wait_drained();

    // random phases across the idle/stall mixes
    send_idle_pct = 0;  recv_stall_pct = 0;  add_random_ops(450); wait_drained();
    send_idle_pct = 73; recv_stall_pct = 0;  add_random_ops(400); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 73; add_random_ops(400); wait_drained();
    send_idle_pct = 25; recv_stall_pct = 25; add_random_ops(300); wait_drained();

    // long receiver hold-off with the sender pushing: fills the queues
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off_cycles = 200;
    add_random_ops(150);
    wait_drained();

    // sender pauses mid-stream until all results are in, then finishes
    add_random_ops(150);
    repeat (40) @(posedge clk);
    hold_sender = 1'b1;
    while (in_push || result_queue.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/qwalu_pkg.sv
rtl/core/qwalu_front.sv
rtl/core/qwalu_back.sv
rtl/core/quadword_integer_alu.sv
verif/quadword_integer_alu_test.sv
